// ===== hdl/bcle_pkg.sv =====
// bcle_pkg: shared types, constants and the character lookup for the braille
// cell layout encoder. No dependencies.

package bcle_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgCellsPerLine = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLineCount    = 1'b1;

  localparam logic [7:0] ResetCellsPerLine = 8'd20;
  localparam logic [7:0] ResetLineCount    = 8'd4;

  localparam logic [5:0] CapitalSign = 6'h20;
  localparam logic [5:0] NumberSign  = 6'h36;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChOne     = 8'h31;
  localparam logic [7:0] ChNine    = 8'h39;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [5:0] LetterDots [26] = '{
    6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
    6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
    6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
  };

  typedef struct packed {
    logic [7:0] line;
    logic [7:0] pos;
    logic [5:0] dots;
    logic       last;
  } cell_res_t;

  typedef struct packed {
    logic valid;
    logic room;
  } q_status_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] dots;
  } look_t;

  function automatic look_t lookup_dots(input logic [7:0] ch);
    look_t      res;
    logic [7:0] lc;
    logic [7:0] off;
    res = '{hit: 1'b1, dots: 6'h00};
    lc  = ch;
    if (ch >= ChUpperA && ch <= ChUpperZ) begin
      lc = ch | 8'h20;
    end
    off = 8'h00;
    priority if (lc >= ChLowerA && lc <= ChLowerZ) begin
      off = lc - ChLowerA;
      res.dots = LetterDots[off[4:0]];
    end else if (lc >= ChOne && lc <= ChNine) begin
      off = lc - ChOne;
      res.dots = LetterDots[off[4:0]];
    end else begin
      unique case (lc)
        ChZero: res.dots = LetterDots[9];
        8'h20:  res.dots = 6'h00;
        8'h2C:  res.dots = 6'h02;
        8'h3B:  res.dots = 6'h06;
        8'h3A:  res.dots = 6'h12;
        8'h2E:  res.dots = 6'h16;
        8'h21:  res.dots = 6'h26;
        8'h3F:  res.dots = 6'h22;
        8'h2D:  res.dots = 6'h24;
        8'h22:  res.dots = 6'h34;
        8'h27:  res.dots = 6'h10;
        8'h5F:  res.dots = CapitalSign;
        8'h23:  res.dots = NumberSign;
        default: res.hit = 1'b0;
      endcase
    end
    return res;
  endfunction

endpackage

// ===== hdl/bcle_queue.sv =====
// bcle_queue: shifting result queue that takes up to two cell beats a cycle
// and hands one a cycle to the output while out_stall_i is low. Depends on bcle_pkg.

module bcle_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_n_i,
  input  bcle_pkg::cell_res_t  push0_i,
  input  bcle_pkg::cell_res_t  push1_i,
  input  logic                 out_stall_i,
  output bcle_pkg::cell_res_t  head_o,
  output bcle_pkg::q_status_t  status_o
);

  bcle_pkg::cell_res_t slot_q [bcle_pkg::QDepth];
  bcle_pkg::cell_res_t slot_d [bcle_pkg::QDepth];
  logic [bcle_pkg::QCntW-1:0] count_q, count_d, cnt_pop;
  logic pop;

  assign status_o.valid = (count_q != '0);
  assign status_o.room  = (count_q <= bcle_pkg::QCntW'(bcle_pkg::QDepth - 2));
  assign pop            = status_o.valid && !out_stall_i;
  assign head_o         = slot_q[0];

  always_comb begin
    cnt_pop = count_q - bcle_pkg::QCntW'(pop);
    count_d = cnt_pop + bcle_pkg::QCntW'(push_n_i);
    for (int k = 0; k < bcle_pkg::QDepth; k++) begin
      slot_d[k] = slot_q[k];
    end
    if (pop) begin
      for (int k = 0; k < bcle_pkg::QDepth - 1; k++) begin
        slot_d[k] = slot_q[k+1];
      end
    end
    for (int k = 0; k < bcle_pkg::QDepth; k++) begin
      if (push_n_i != 2'd0 && cnt_pop == bcle_pkg::QCntW'(k)) begin
        slot_d[k] = push0_i;
      end
      if (push_n_i == 2'd2 && cnt_pop + 1'b1 == bcle_pkg::QCntW'(k)) begin
        slot_d[k] = push1_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < bcle_pkg::QDepth; k++) begin
      slot_q[k] <= slot_d[k];
    end
  end

endmodule

// ===== hdl/braille_cell_layout_encoder.sv =====
// braille_cell_layout_encoder: top level, grade-1 braille cell layout.
// Depends on bcle_pkg and bcle_queue.
//
// Usage: text characters enter on the input channel (in_valid_i / in_stall_o)
// with starts_text_i marking the first character of a new text. Each
// character gives zero, one or two cell write beats on the output channel
// (out_valid_o / out_stall_i): a capital or number sign cell, then the
// character's own cell, the final one flagged by last_of_run_o.
// The cells of a taken character are registered into the queue and leave
// from its head in order, one per cycle while the output is not stalled.
// With four entries, characters that give one cell can be taken every
// cycle; those with a sign cell are held back by the single output port.
// The input is stalled while the queue has fewer than two free entries;
// a stalled output holds its beat and the queue fills behind it.
// Reset empties the queue, puts the cursor at line 0, cell 0, clears the stop
// flag and loads 20 cells per line and 4 lines. The register port takes
// cells_per_line at index 0 and line_count at index 1, written while idle.

module braille_cell_layout_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcle_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          starts_text_i,
  input  logic [7:0]                    character_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    line_index_o,
  output logic [7:0]                    cell_index_o,
  output logic [5:0]                    dot_pattern_o,
  output logic                          last_of_run_o
);

  logic [7:0] cpl_q, lc_q;
  logic [7:0] line_q, line_d, cell_q, cell_d;
  logic       stopped_q, stopped_d;

  logic [7:0] eff_line, eff_cell, cell1;
  logic       eff_stop, is_upper, is_digit, fit0, fit1, pre, main_w, in_acc;
  logic [1:0] n_cells, push_n;
  bcle_pkg::look_t     look;
  bcle_pkg::cell_res_t res0, res1, head;
  bcle_pkg::q_status_t qstat;

  assign in_stall_o = !qstat.room;
  assign in_acc     = in_valid_i && qstat.room;

  always_comb begin
    eff_line = starts_text_i ? 8'd0 : line_q;
    eff_cell = starts_text_i ? 8'd0 : cell_q;
    eff_stop = starts_text_i ? 1'b0 : stopped_q;
    is_upper = character_i >= bcle_pkg::ChUpperA && character_i <= bcle_pkg::ChUpperZ;
    is_digit = character_i >= bcle_pkg::ChZero && character_i <= bcle_pkg::ChNine;
    fit0     = eff_cell < cpl_q && eff_line < lc_q;
    pre      = (is_upper || is_digit) && fit0;
    cell1    = eff_cell + 8'(pre);
    fit1     = cell1 < cpl_q && eff_line < lc_q;
    look     = bcle_pkg::lookup_dots(character_i);
    main_w   = fit1 && look.hit;

    if (eff_stop || character_i == bcle_pkg::ChNewline) begin
      n_cells = 2'd0;
    end else begin
      n_cells = 2'(pre) + 2'(main_w);
    end
    push_n = in_acc ? n_cells : 2'd0;

    res0.line = eff_line;
    res0.pos  = eff_cell;
    if (pre) begin
      res0.dots = is_upper ? bcle_pkg::CapitalSign : bcle_pkg::NumberSign;
      res0.last = !main_w;
    end else begin
      res0.dots = look.dots;
      res0.last = 1'b1;
    end
    res1.line = eff_line;
    res1.pos  = cell1;
    res1.dots = look.dots;
    res1.last = 1'b1;

    line_d    = line_q;
    cell_d    = cell_q;
    stopped_d = stopped_q;
    if (in_acc) begin
      line_d    = eff_line;
      cell_d    = eff_cell;
      stopped_d = eff_stop;
      if (!eff_stop) begin
        if (character_i == bcle_pkg::ChNewline) begin
          line_d = (eff_line == 8'hFF) ? eff_line : eff_line + 8'd1;
          cell_d = 8'd0;
        end else begin
          cell_d    = cell1 + 8'(main_w);
          stopped_d = !fit1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpl_q     <= bcle_pkg::ResetCellsPerLine;
      lc_q      <= bcle_pkg::ResetLineCount;
      line_q    <= 8'd0;
      cell_q    <= 8'd0;
      stopped_q <= 1'b0;
    end else begin
      line_q    <= line_d;
      cell_q    <= cell_d;
      stopped_q <= stopped_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bcle_pkg::CfgCellsPerLine: cpl_q <= cfg_data_i;
          bcle_pkg::CfgLineCount:    lc_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  bcle_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push0_i     (res0),
    .push1_i     (res1),
    .out_stall_i (out_stall_i),
    .head_o      (head),
    .status_o    (qstat)
  );

  assign out_valid_o   = qstat.valid;
  assign line_index_o  = head.line;
  assign cell_index_o  = head.pos;
  assign dot_pattern_o = head.dots;
  assign last_of_run_o = head.last;

  // a stopped text gives no cells until a new text starts
  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && stopped_q && !starts_text_i) |-> push_n == 2'd0)
    else $error("cells written while stopped");

  // every written cell lies inside the grid
  a_cell_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> (res0.pos < cpl_q && res0.line < lc_q))
    else $error("cell written outside the grid");

  // the stop flag only rises on a taken character
  a_stop_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stopped_q) |-> $past(in_acc))
    else $error("stop flag set without an input beat");

endmodule

// ===== tb/tb_braille_cell_layout_encoder.sv =====
`timescale 1ns / 100ps
// tb_braille_cell_layout_encoder: self-checking bench for the braille cell layout encoder
// drives text beats and register writes, predicts each cell write and checks output beats
// in order; depends on bcle_pkg and braille_cell_layout_encoder

module tb_braille_cell_layout_encoder;

  localparam int QuietLimit = 3000;
  localparam logic [7:0] PunctChars [12] = '{
    ",", ";", ":", ".", "!", "?", "-", "\"", "'", "_", "#", " "
  };

  class braille_scoreboard;
    localparam logic [5:0] AlphaDots [26] = '{
      6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
      6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
      6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
    };
    localparam logic [5:0] CapDots = 6'h20;
    localparam logic [5:0] NumDots = 6'h36;

    logic [7:0]          grid_cells;
    logic [7:0]          grid_lines;
    logic [7:0]          cur_line;
    logic [7:0]          cur_cell;
    bit                  halted;
    bcle_pkg::cell_res_t writes_due[$];
    int                  errors;

    function new();
      grid_cells = 8'd20;
      grid_lines = 8'd4;
      cur_line   = 8'd0;
      cur_cell   = 8'd0;
      halted     = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [bcle_pkg::CfgIdxW-1:0] idx, logic [7:0] val);
      if (idx == bcle_pkg::CfgCellsPerLine) grid_cells = val;
      else grid_lines = val;
    endfunction

    function bit fits();
      return cur_cell < grid_cells && cur_line < grid_lines;
    endfunction

    function void put_cell(logic [5:0] dots);
      bcle_pkg::cell_res_t w;
      w.line = cur_line;
      w.pos  = cur_cell;
      w.dots = dots;
      w.last = 1'b0;
      writes_due.push_back(w);
      cur_cell = cur_cell + 8'd1;
    endfunction

    function bit char_dots(logic [7:0] ch, output logic [5:0] dots);
      logic [7:0] lc;
      logic [7:0] off;
      lc = ch;
      dots = 6'h00;
      if (ch >= "A" && ch <= "Z") lc = ch + 8'd32;
      if (lc >= "a" && lc <= "z") begin
        off = lc - "a";
        dots = AlphaDots[off[4:0]];
        return 1'b1;
      end
      if (lc >= "1" && lc <= "9") begin
        off = lc - "1";
        dots = AlphaDots[off[4:0]];
        return 1'b1;
      end
      case (lc)
        "0":  dots = AlphaDots[9];
        " ":  dots = 6'h00;
        ",":  dots = 6'h02;
        ";":  dots = 6'h06;
        ":":  dots = 6'h12;
        ".":  dots = 6'h16;
        "!":  dots = 6'h26;
        "?":  dots = 6'h22;
        "-":  dots = 6'h24;
        "\"": dots = 6'h34;
        "'":  dots = 6'h10;
        "_":  dots = CapDots;
        "#":  dots = NumDots;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // works out the cell writes that one accepted character beat causes
    function void take_char(bit st, logic [7:0] ch);
      int                  n_prior;
      logic [5:0]          dots;
      bcle_pkg::cell_res_t w;
      n_prior = writes_due.size();
      if (st) begin
        cur_line = 8'd0;
        cur_cell = 8'd0;
        halted   = 1'b0;
      end
      if (halted) return;
      if (ch == bcle_pkg::ChNewline) begin
        if (cur_line != 8'hFF) cur_line = cur_line + 8'd1;
        cur_cell = 8'd0;
        return;
      end
      if (ch >= "A" && ch <= "Z" && fits()) put_cell(CapDots);
      if (ch >= "0" && ch <= "9" && fits()) put_cell(NumDots);
      if (!fits()) halted = 1'b1;
      else if (char_dots(ch, dots)) put_cell(dots);
      if (writes_due.size() > n_prior) begin
        w = writes_due.pop_back();
        w.last = 1'b1;
        writes_due.push_back(w);
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_cell(bcle_pkg::cell_res_t got);
      bcle_pkg::cell_res_t want;
      if (writes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected cell write line %0d cell %0d dots %h",
                                  got.line, got.pos, got.dots));
        return;
      end
      want = writes_due.pop_front();
      if (got.line !== want.line)
        report_mismatch($sformatf("line_index %0d, expected %0d", got.line, want.line));
      if (got.pos !== want.pos)
        report_mismatch($sformatf("cell_index %0d, expected %0d", got.pos, want.pos));
      if (got.dots !== want.dots)
        report_mismatch($sformatf("dot_pattern %h, expected %h", got.dots, want.dots));
      if (got.last !== want.last)
        report_mismatch($sformatf("last_of_run %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [bcle_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [7:0]                   cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         starts_text_i;
  logic [7:0]                   character_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [7:0]                   line_index_o;
  logic [7:0]                   cell_index_o;
  logic [5:0]                   dot_pattern_o;
  logic                         last_of_run_o;

  braille_scoreboard sb = new();
  bit tx_idle;
  bit rx_idle;
  bit hold_req;
  int quiet_cycles;

  braille_cell_layout_encoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .starts_text_i (starts_text_i),
    .character_i   (character_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_index_o  (line_index_o),
    .cell_index_o  (cell_index_o),
    .dot_pattern_o (dot_pattern_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input beats are noted before output beats so a same-edge expectation exists
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.take_char(starts_text_i, character_i);
      if (out_valid_o && !out_stall_i)
        sb.check_cell(bcle_pkg::cell_res_t'{line_index_o, cell_index_o, dot_pattern_o,
                                            last_of_run_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls when rx_idle is set, plus one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (120) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= rx_idle && ($urandom_range(0, 99) < 25);
      end
    end
  end

  task automatic send_char(input bit st, input logic [7:0] ch);
    if (tx_idle && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    starts_text_i <= st;
    character_i   <= ch;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic send_text(input bit st, input string s);
    for (int i = 0; i < s.len(); i++) send_char(st && i == 0, s[i]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.writes_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] cpl, input logic [7:0] lines);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= bcle_pkg::CfgCellsPerLine;
    cfg_data_i  <= cpl;
    @(posedge clk_i);
    cfg_index_i <= bcle_pkg::CfgLineCount;
    cfg_data_i  <= lines;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return "a" + 8'($urandom_range(0, 25));
    if (r < 45) return "A" + 8'($urandom_range(0, 25));
    if (r < 57) return "0" + 8'($urandom_range(0, 9));
    if (r < 67) return PunctChars[4'($urandom_range(0, 11))];
    if (r < 80) return bcle_pkg::ChNewline;
    if (r < 90) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  // texts of random length, each opened by a start beat, with the odd stray start
  task automatic run_phase(input logic [7:0] cpl, input logic [7:0] lines,
                           input int n_items, input bit idling, input bit with_hold);
    int sent;
    bit st;
    drain();
    write_regs(cpl, lines);
    tx_idle = idling;
    rx_idle = idling;
    sent = 0;
    while (sent < n_items) begin
      for (int i = 0; i < $urandom_range(1, 30) && sent < n_items; i++) begin
        st = (i == 0) || ($urandom_range(0, 99) < 3);
        send_char(st, pick_char());
        sent++;
        if (with_hold && sent == 20) hold_req = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = bcle_pkg::CfgCellsPerLine;
    cfg_data_i    = 8'd0;
    in_valid_i    = 1'b0;
    starts_text_i = 1'b0;
    character_i   = 8'd0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset grid: letters, digits, every mapped punctuation mark, signs, unknown codes
    send_text(1'b1, "aAzZ019 ,;:\n.!?-\"'_#");
    send_char(1'b0, 8'h00);
    send_char(1'b0, 8'h80);
    send_char(1'b0, 8'hFF);
    send_char(1'b0, "~");

    // sign cell fits but its letter does not, then stopped text
    drain();
    write_regs(8'd2, 8'd1);
    send_text(1'b1, "aBc\n");
    send_text(1'b1, "5\nx");
    send_text(1'b1, "A");

    // empty grid
    drain();
    write_regs(8'd0, 8'd0);
    send_text(1'b1, "a");
    send_text(1'b1, "\n7");

    // line counter saturates rather than wrapping back to line 0
    drain();
    write_regs(8'd255, 8'd255);
    send_char(1'b1, "a");
    repeat (260) send_char(1'b0, bcle_pkg::ChNewline);
    send_char(1'b0, "b");
    send_text(1'b1, "Q");

    run_phase(8'd20, 8'd4, 40, 1'b0, 1'b0);
    run_phase(8'd255, 8'd255, 50, 1'b1, 1'b1);
    run_phase(8'd8, 8'd3, 40, 1'b1, 1'b0);
    run_phase(8'd1, 8'd1, 30, 1'b1, 1'b0);
    run_phase(8'd0, 8'd3, 20, 1'b1, 1'b0);
    run_phase(8'd6, 8'd0, 20, 1'b1, 1'b0);
    run_phase(8'd3, 8'd2, 30, 1'b1, 1'b0);
    run_phase(8'($urandom_range(1, 16)), 8'($urandom_range(1, 6)), 30, 1'b1, 1'b0);
    run_phase(8'($urandom_range(1, 16)), 8'($urandom_range(1, 6)), 30, 1'b1, 1'b0);
    drain();

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
